[hdl/dff_pkg.sv]
// Shared constants and types for the decimal field formatter.
package dff_pkg;

   localparam int FIELD_CHARS = 16;
   localparam int VALUE_BITS  = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int CNT_W       = $clog2(FIELD_CHARS + 1);
   localparam int POS_W       = $clog2(FIELD_CHARS);
   localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   localparam logic [1:0] ALIGN_LEFT   = 2'd0;
   localparam logic [1:0] ALIGN_CENTER = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SETUP = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

endpackage

[hdl/decimal_field_formatter.sv]
// Decimal field formatter: binary to BCD, field layout, one ASCII character per word out.
// Steps: shift-add-3 conversion of the VALUE_BITS (32) input bits in the BCD adjust unit
// (ST_CONV), a layout step (ST_SETUP), then one registered character word at a time (ST_EMIT).
// Throughput: one request at a time; characters leave one per cycle while rsp_ready is high.
// A request whose clamped width, rounded down to even, is zero is accepted and produces no words.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module decimal_field_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_number_value,
   input  logic [7:0]  req_field_width,
   input  logic [1:0]  req_alignment,
   input  logic [7:0]  req_forced_digits,
   input  logic [3:0]  req_fraction_digits,
   input  logic        req_blank_enable,
   input  logic [3:0]  req_blank_digit,
   input  logic [7:0]  req_display_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_field_address,
   output logic [3:0]  rsp_char_index,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last_char
);
   import dff_pkg::*;

   state_type                 state_ff, state_in;
   logic [VALUE_BITS-1:0]     value_ff, value_in;
   logic [BCD_DIGITS*4-1:0]   bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          show_ff, show_in;
   logic [CNT_W-1:0]          fend_ff, fend_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [1:0]                align_ff, align_in;
   logic [7:0]                forced_ff, forced_in;
   logic [3:0]                point_ff, point_in;
   logic                      blank_en_ff, blank_en_in;
   logic [3:0]                blank_ff, blank_in;
   logic [7:0]                addr_ff, addr_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_addr_ff, rsp_addr_in;
   logic [3:0]                rsp_index_ff, rsp_index_in;
   logic [7:0]                rsp_code_ff, rsp_code_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]          n_req;
   logic [BCD_DIGITS*4-1:0]   bcd_adj;
   logic [BCD_DIGITS*4-1:0]   bcd_step;
   logic [CNT_W-1:0]          natural;
   logic [CNT_W-1:0]          shown_digits;
   logic [CNT_W-1:0]          show_n;
   logic [CNT_W-1:0]          gap;
   logic [CNT_W-1:0]          start;
   logic [CNT_W:0]            span;
   logic [POS_W-1:0]          du;
   logic [POS_W-1:0]          du_m1;
   logic [FIELD_CHARS*4-1:0]  bcd_ext;
   logic [7:0]                char_code;
   logic                      blank_hit;
   logic                      load;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_field_address = rsp_addr_ff;
   assign rsp_char_index    = rsp_index_ff;
   assign rsp_char_code     = rsp_code_ff;
   assign rsp_last_char     = rsp_last_ff;

   assign n_req = ((req_field_width > FIELD_CHARS) ? CNT_W'(FIELD_CHARS)
                                                   : CNT_W'(req_field_width)) & ~CNT_W'(1);

   // shift-add-3 adjust, one input bit per cycle
   always_comb begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
         bcd_adj[k*4 +: 4] = (bcd_ff[k*4 +: 4] >= 4'd5) ? bcd_ff[k*4 +: 4] + 4'd3
                                                         : bcd_ff[k*4 +: 4];
      end
      bcd_step = {bcd_adj[BCD_DIGITS*4-2:0], value_ff[VALUE_BITS-1]};
   end

   // layout: shown digits, run length and start of the shown run
   always_comb begin
      natural = CNT_W'(1);
      for (int k = 1; k < BCD_DIGITS; k++) begin
         if (bcd_ff[k*4 +: 4] != 4'd0) begin
            natural = CNT_W'(k + 1);
         end
      end
      if (forced_ff != 8'd0) begin
         shown_digits = (forced_ff > 8'(n_ff)) ? n_ff : CNT_W'(forced_ff);
      end else begin
         shown_digits = (natural > n_ff) ? n_ff : natural;
      end
      if (point_ff != 4'd0 && shown_digits >= n_ff) begin
         shown_digits = shown_digits - CNT_W'(1);
      end
      show_n = shown_digits + CNT_W'(point_ff != 4'd0);
      gap    = n_ff - show_n;
      unique case (align_ff)
         ALIGN_LEFT:   start = '0;
         ALIGN_CENTER: start = gap >> 1;
         default:      start = gap;
      endcase
   end

   // character at pos_ff
   always_comb begin
      bcd_ext = (FIELD_CHARS*4)'(bcd_ff);
      span    = {1'b0, fend_ff} - (CNT_W+1)'(pos_ff);
      du      = span[POS_W-1:0];
      du_m1   = du - POS_W'(1);
      if (point_ff != 4'd0) begin
         blank_hit = blank_en_ff && (CNT_W'(blank_ff) < show_ff) &&
                     (((blank_ff >= point_ff) && (CNT_W'(du) == CNT_W'(blank_ff) + CNT_W'(1))) ||
                      ((blank_ff <  point_ff) && (du == POS_W'(blank_ff))));
         if (span[CNT_W]) begin
            char_code = CH_SPACE;
         end else if (4'(du) < point_ff) begin
            char_code = CH_ZERO + 8'(bcd_ext[du*4 +: 4]);
         end else if (4'(du) == point_ff) begin
            char_code = CH_POINT;
         end else if (CNT_W'(du) <= show_ff) begin
            char_code = CH_ZERO + 8'(bcd_ext[du_m1*4 +: 4]);
         end else begin
            char_code = CH_SPACE;
         end
      end else begin
         blank_hit = blank_en_ff && (CNT_W'(blank_ff) < show_ff) &&
                     (du == POS_W'(blank_ff));
         if (!span[CNT_W] && CNT_W'(du) < show_ff) begin
            char_code = CH_ZERO + 8'(bcd_ext[du*4 +: 4]);
         end else begin
            char_code = CH_SPACE;
         end
      end
      if (blank_hit && !span[CNT_W]) begin
         char_code = CH_SPACE;
      end
   end

   assign load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      n_in         = n_ff;
      show_in      = show_ff;
      fend_in      = fend_ff;
      pos_in       = pos_ff;
      align_in     = align_ff;
      forced_in    = forced_ff;
      point_in     = point_ff;
      blank_en_in  = blank_en_ff;
      blank_in     = blank_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_index_in = rsp_index_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in    = req_number_value[VALUE_BITS-1:0];
               bcd_in      = '0;
               bit_cnt_in  = '0;
               n_in        = n_req;
               align_in    = req_alignment;
               forced_in   = req_forced_digits;
               point_in    = req_fraction_digits;
               blank_en_in = req_blank_enable;
               blank_in    = req_blank_digit;
               addr_in     = req_display_address;
               if (n_req != '0) begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            value_in   = value_ff << 1;
            bcd_in     = bcd_step;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_BITS - 1)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            show_in  = shown_digits;
            fend_in  = start + show_n - CNT_W'(1);
            pos_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = addr_ff;
               rsp_index_in = 4'(pos_ff);
               rsp_code_in  = char_code;
               rsp_last_in  = (CNT_W'(pos_ff) == n_ff - CNT_W'(1));
               pos_in       = pos_ff + POS_W'(1);
               if (CNT_W'(pos_ff) == n_ff - CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      n_ff         <= n_in;
      show_ff      <= show_in;
      fend_ff      <= fend_in;
      pos_ff       <= pos_in;
      align_ff     <= align_in;
      forced_ff    <= forced_in;
      point_ff     <= point_in;
      blank_en_ff  <= blank_en_in;
      blank_ff     <= blank_in;
      addr_ff      <= addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_index_ff <= rsp_index_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

[hdl/dff_checker.sv]
// Port-level checks for the decimal field formatter, bound to the top level.
module dff_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_field_width,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_char_index,
   input logic [7:0] rsp_char_code,
   input logic       rsp_last_char
);

   // held word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code) &&
                                  $stable(rsp_char_index))
      else $error("rsp word changed while stalled");

   // busy after taking a request that shows a field
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_field_width > 8'd1) |=> !req_ready)
      else $error("req_ready high right after an accept");

   // no new request while a field is still being sent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |-> !req_ready)
      else $error("req_ready high in the middle of a field");

   // field widths are even, so the last word sits at an odd index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_char_index[0])
      else $error("last word at even index");

endmodule

bind decimal_field_formatter dff_checker u_dff_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_field_width (req_field_width),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_char_index  (rsp_char_index),
   .rsp_char_code   (rsp_char_code),
   .rsp_last_char   (rsp_last_char)
);
